// ----- sv/lemm_pkg.sv -----
// Shared constants, types, lattice address helpers and the control program of the move core.
package lemm_pkg;

  // Lattice geometry and fixed-point format.
  localparam int SIDE       = 32;
  localparam int PROB_BITS  = 16;
  localparam int CELLS      = SIDE * SIDE * SIDE;
  localparam int COORD_W    = $clog2(SIDE);
  localparam int CELL_W     = $clog2(CELLS);

  // Field widths of the input and result beats.
  localparam int KIND_W     = 2;
  localparam int IN_COORD_W = 5;
  localparam int IN_COORDS  = 1 << IN_COORD_W;
  localparam int DIR_W      = 3;
  localparam int SLOT_W     = 5;
  localparam int PAY_W      = 17;
  localparam int ST_W       = 3;
  localparam int DE_W       = 5;
  localparam int OCC_W      = 2;

  // Threshold table and compare widths.
  localparam int SLOTS      = 26;
  localparam int THR_W      = PROB_BITS + 1;
  localparam int CMP_W      = (PAY_W > THR_W) ? PAY_W : THR_W;
  localparam logic [CMP_W-1:0] PROB_ONE = CMP_W'(1) << PROB_BITS;

  // Neighbor counting.
  localparam int NBRS       = 6;
  localparam int CNT_W      = 3;

  // Occupant codes and bond counts.
  localparam logic [OCC_W-1:0] OCC_VACANT = 2'd0;
  localparam logic [OCC_W-1:0] OCC_RED    = 2'd1;
  localparam logic [OCC_W-1:0] OCC_BLUE   = 2'd2;
  localparam logic [2:0]       RED_CONN   = 3'd3;
  localparam logic [2:0]       BLUE_CONN  = 3'd5;

  // Neighbor directions.
  localparam logic [DIR_W-1:0] DIR_IM   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_IP   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_JM   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_JP   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_KM   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_LAST = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_WSITE = 2'd0,
    KIND_WTHR  = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_WRITTEN = 3'd0,
    ST_VACANT  = 3'd1,
    ST_SAME    = 3'd2,
    ST_ACCEPT  = 3'd3,
    ST_REJECT  = 3'd4,
    ST_BAD     = 3'd5,
    ST_READ    = 3'd6
  } status_e;

  // Control program addresses.
  localparam int STEP_W = 4;
  typedef enum logic [STEP_W-1:0] {
    S_WSITE   = 4'd0,
    S_WTHR    = 4'd1,
    S_RSITE   = 4'd2,
    S_FIN     = 4'd3,
    S_EMIT    = 4'd4,
    S_MSITE   = 4'd5,
    S_MMATE   = 4'd6,
    S_MFIRST  = 4'd7,
    S_MLOOP   = 4'd8,
    S_MLAST   = 4'd9,
    S_MENERGY = 4'd10,
    S_MDECIDE = 4'd11,
    S_MWSITE  = 4'd12,
    S_MWMATE  = 4'd13
  } step_e;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_READ,
    MEM_WRITE
  } memop_e;

  typedef enum logic [1:0] {
    AS_SITE,
    AS_MATE,
    AS_NBR
  } asel_e;

  typedef enum logic [1:0] {
    WS_PAY,
    WS_A,
    WS_B
  } wsel_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_WSITE,
    A_WTHR,
    A_READ,
    A_CAPA,
    A_CAPB,
    A_ACC,
    A_ENERGY,
    A_DECIDE,
    A_EMIT
  } act_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_SKIP,
    C_SAME,
    C_LOOP,
    C_REJECT
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    memop_e mem_op;
    asel_e  addr_sel;
    wsel_e  wdata_sel;
    act_e   act;
    cond_e  cond;
    step_e  target;
  } ucode_t;

  // Coordinate reduction modulo SIDE by repeated compare and subtract.
  function automatic logic [COORD_W-1:0] wrap_coord(input logic [IN_COORD_W-1:0] c);
    logic [IN_COORD_W:0] r;
    r = {1'b0, c};
    for (int n = 0; n < IN_COORDS / SIDE; n++) begin
      if (r >= (IN_COORD_W + 1)'(SIDE)) begin
        r = r - (IN_COORD_W + 1)'(SIDE);
      end
    end
    return COORD_W'(r);
  endfunction

  function automatic logic [COORD_W-1:0] wrap_down(input logic [COORD_W-1:0] c);
    return (c == '0) ? COORD_W'(SIDE - 1) : c - COORD_W'(1);
  endfunction

  function automatic logic [COORD_W-1:0] wrap_up(input logic [COORD_W-1:0] c);
    return (c == COORD_W'(SIDE - 1)) ? '0 : c + COORD_W'(1);
  endfunction

  // Linear address: k fastest, i slowest.
  function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] i,
                                                   input logic [COORD_W-1:0] j,
                                                   input logic [COORD_W-1:0] k);
    logic [CELL_W-1:0] idx;
    idx = CELL_W'(i) * CELL_W'(SIDE * SIDE) + CELL_W'(j) * CELL_W'(SIDE) + CELL_W'(k);
    return idx;
  endfunction

  // Address of the neighbor in direction d, wrapping at the lattice faces.
  function automatic logic [CELL_W-1:0] nbr_index(input logic [COORD_W-1:0] i,
                                                  input logic [COORD_W-1:0] j,
                                                  input logic [COORD_W-1:0] k,
                                                  input logic [DIR_W-1:0]   d);
    logic [COORD_W-1:0] ni;
    logic [COORD_W-1:0] nj;
    logic [COORD_W-1:0] nk;
    ni = i;
    nj = j;
    nk = k;
    case (d)
      DIR_IM:  ni = wrap_down(i);
      DIR_IP:  ni = wrap_up(i);
      DIR_JM:  nj = wrap_down(j);
      DIR_JP:  nj = wrap_up(j);
      DIR_KM:  nk = wrap_down(k);
      default: nk = wrap_up(k);
    endcase
    return cell_index(ni, nj, nk);
  endfunction

  // Site energy (C - r)^2; a vacant site has none.
  function automatic logic [DE_W-1:0] site_energy(input logic [OCC_W-1:0] occ,
                                                  input logic [CNT_W-1:0] reds);
    logic [2:0] conn;
    logic [2:0] diff;
    logic [5:0] sq;
    conn = (occ == OCC_RED) ? RED_CONN : BLUE_CONN;
    diff = (conn >= reds) ? conn - reds : reds - conn;
    sq   = {3'b000, diff} * {3'b000, diff};
    return (occ == OCC_VACANT) ? '0 : DE_W'(sq);
  endfunction

  // First program step for each operation kind.
  function automatic step_e entry_step(input kind_e k);
    step_e s;
    case (k)
      KIND_WSITE: s = S_WSITE;
      KIND_WTHR:  s = S_WTHR;
      KIND_MOVE:  s = S_MSITE;
      default:    s = S_RSITE;
    endcase
    return s;
  endfunction

  // The control program: one word per step.
  function automatic ucode_t ucode(input step_e s);
    ucode_t u;
    u = '{mem_op: MEM_NONE, addr_sel: AS_SITE, wdata_sel: WS_PAY,
          act: A_NONE, cond: C_NEXT, target: S_FIN};
    case (s)
      S_WSITE: begin
        u.mem_op = MEM_WRITE;
        u.act    = A_WSITE;
        u.cond   = C_ALWAYS;
      end
      S_WTHR: begin
        u.act  = A_WTHR;
        u.cond = C_ALWAYS;
      end
      S_RSITE: begin
        u.act = A_READ;
      end
      S_FIN: begin
        u.mem_op = MEM_READ;
      end
      S_EMIT: begin
        u.act = A_EMIT;
      end
      S_MSITE: begin
        u.mem_op = MEM_READ;
      end
      S_MMATE: begin
        u.mem_op   = MEM_READ;
        u.addr_sel = AS_MATE;
        u.act      = A_CAPA;
        u.cond     = C_SKIP;
      end
      S_MFIRST: begin
        u.mem_op   = MEM_READ;
        u.addr_sel = AS_NBR;
        u.act      = A_CAPB;
        u.cond     = C_SAME;
      end
      S_MLOOP: begin
        u.mem_op   = MEM_READ;
        u.addr_sel = AS_NBR;
        u.act      = A_ACC;
        u.cond     = C_LOOP;
        u.target   = S_MLOOP;
      end
      S_MLAST: begin
        u.act = A_ACC;
      end
      S_MENERGY: begin
        u.act = A_ENERGY;
      end
      S_MDECIDE: begin
        u.act  = A_DECIDE;
        u.cond = C_REJECT;
      end
      S_MWSITE: begin
        u.mem_op    = MEM_WRITE;
        u.wdata_sel = WS_B;
      end
      S_MWMATE: begin
        u.mem_op    = MEM_WRITE;
        u.addr_sel  = AS_MATE;
        u.wdata_sel = WS_A;
        u.cond      = C_ALWAYS;
      end
      default: begin
        u.cond = C_ALWAYS;
      end
    endcase
    return u;
  endfunction

endpackage

// ----- sv/lattice_exchange_metropolis_move_core.sv -----
// Exchange-move Metropolis core: lattice memory, threshold table and microcoded control.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata[39:0] tuser[1:0]  one operation request
//  m_axis    out        tvalid tready tdata[7:0]  tuser[2:0]  one result per request
//
// A site write, threshold write or site read runs the shortest program from accept to
// result; a move on a vacant site or with a bad direction runs longer, a same-type skip
// longer still, a rejected move longer again and an accepted one longest. The next beat
// can be taken in the cycle after the result is loaded.
// The single lattice memory port allows one site access per cycle.
// After reset a clearing pass writes all 32768 sites vacant, one per cycle; tready is
// low during it. A stalled result holds the control program at its last step only
// once a further request has been taken.
module lattice_exchange_metropolis_move_core
  import lemm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: coord_i[4:0], coord_j[9:5], coord_k[14:10], direction[17:15],
  //        table_slot[22:18], payload[39:23]
  input  logic [39:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: energy_change[4:0], site_type[6:5], zero[7]
  output logic [7:0]  m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]  m_axis_tuser
);

  // Control state.
  logic              busy_q, busy_d;
  step_e             upc_q, upc_d;
  logic              out_valid_q, out_valid_d;
  logic              clr_done_q, clr_done_d;
  logic [CELL_W-1:0] clr_addr_q, clr_addr_d;

  // Request and working registers.
  logic [COORD_W-1:0] ci_q, cj_q, ck_q;
  logic [DIR_W-1:0]   dir_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [PAY_W-1:0]   pay_q;
  logic [OCC_W-1:0]   a_q, b_q;
  logic [CNT_W-1:0]   cnt_q, reds_q;
  logic [DE_W-1:0]    de_q;
  status_e            status_q;
  logic [THR_W-1:0]   thr_q [SLOTS];

  // Result registers.
  status_e          out_status_q;
  logic [DE_W-1:0]  out_de_q;
  logic [OCC_W-1:0] out_occ_q;

  // Lattice memory.
  logic [OCC_W-1:0]  lat_mem [CELLS];
  logic [OCC_W-1:0]  mem_rdata_q;
  logic              mem_we;
  logic [CELL_W-1:0] mem_addr;
  logic [OCC_W-1:0]  mem_wdata;

  // Decoded control and datapath values.
  ucode_t            uw;
  logic              in_accept;
  logic              emit;
  logic              pay_bad;
  logic              slot_bad;
  logic              accept_move;
  logic [CELL_W-1:0] site_idx, mate_idx, nbr_idx;
  logic [CNT_W-1:0]  reds_after;
  logic [DE_W-1:0]   e_before, e_after, de_w;
  logic [CMP_W-1:0]  thr_sat;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q && clr_done_q;
  assign uw            = ucode(upc_q);

  // Result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_de_q};

  // Lattice addresses of the site, its partner and the counted neighbor.
  assign site_idx = cell_index(ci_q, cj_q, ck_q);
  assign mate_idx = nbr_index(ci_q, cj_q, ck_q, dir_q);
  assign nbr_idx  = nbr_index(ci_q, cj_q, ck_q, cnt_q);

  // Value checks.
  assign pay_bad  = pay_q > PAY_W'(OCC_BLUE);
  assign slot_bad = slot_q > SLOT_W'(SLOTS - 1);
  assign thr_sat  = (CMP_W'(pay_q) > PROB_ONE) ? PROB_ONE : CMP_W'(pay_q);

  // Energies before and after the swap. Only the partner among the six neighbors
  // changes, so the red count after the swap follows from the one before.
  assign reds_after = reds_q - CNT_W'(b_q == OCC_RED) + CNT_W'(a_q == OCC_RED);
  assign e_before   = site_energy(a_q, reds_q);
  assign e_after    = site_energy(b_q, reds_after);
  assign de_w       = (e_after >= e_before) ? e_after - e_before : e_before - e_after;

  // Metropolis test against the threshold for this energy change.
  assign accept_move = CMP_W'(pay_q) <= CMP_W'(thr_q[de_q]);

  // Memory port: the clearing pass owns it until every site is vacant.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = site_idx;
    mem_wdata = OCC_VACANT;
    if (!clr_done_q) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_q;
    end else begin
      case (uw.addr_sel)
        AS_MATE: mem_addr = mate_idx;
        AS_NBR:  mem_addr = nbr_idx;
        default: mem_addr = site_idx;
      endcase
      case (uw.wdata_sel)
        WS_A:    mem_wdata = a_q;
        WS_B:    mem_wdata = b_q;
        default: mem_wdata = pay_q[OCC_W-1:0];
      endcase
      mem_we = busy_q && (uw.mem_op == MEM_WRITE) && !((uw.act == A_WSITE) && pay_bad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lat_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= lat_mem[mem_addr];
  end

  // Sequencer: next step, busy flag, result valid and the clearing pass.
  always_comb begin
    upc_d       = upc_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    clr_done_d  = clr_done_q;
    clr_addr_d  = clr_addr_q;
    emit        = 1'b0;

    if (!clr_done_q) begin
      clr_addr_d = clr_addr_q + CELL_W'(1);
      clr_done_d = (clr_addr_q == CELL_W'(CELLS - 1));
    end

    if (in_accept) begin
      busy_d = 1'b1;
      upc_d  = entry_step(kind_e'(s_axis_tuser));
    end else if (busy_q) begin
      case (uw.cond)
        C_ALWAYS: upc_d = uw.target;
        C_SKIP: begin
          upc_d = ((mem_rdata_q == OCC_VACANT) || (dir_q > DIR_LAST)) ?
                  uw.target : step_e'(upc_q + STEP_W'(1));
        end
        C_SAME:   upc_d = (mem_rdata_q == a_q) ? uw.target : step_e'(upc_q + STEP_W'(1));
        C_LOOP: begin
          upc_d = (cnt_q != CNT_W'(NBRS - 1)) ? uw.target : step_e'(upc_q + STEP_W'(1));
        end
        C_REJECT: upc_d = !accept_move ? uw.target : step_e'(upc_q + STEP_W'(1));
        default:  upc_d = step_e'(upc_q + STEP_W'(1));
      endcase
      if (uw.act == A_EMIT) begin
        // Hold here until the result register is free.
        upc_d = upc_q;
        if (!out_valid_q || m_axis_tready) begin
          emit        = 1'b1;
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= S_FIN;
      out_valid_q <= 1'b0;
      clr_done_q  <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      clr_done_q  <= clr_done_d;
      clr_addr_q  <= clr_addr_d;
    end
  end

  // Datapath actions named by the control word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ci_q     <= wrap_coord(s_axis_tdata[4:0]);
      cj_q     <= wrap_coord(s_axis_tdata[9:5]);
      ck_q     <= wrap_coord(s_axis_tdata[14:10]);
      dir_q    <= s_axis_tdata[17:15];
      slot_q   <= s_axis_tdata[22:18];
      pay_q    <= s_axis_tdata[39:23];
      status_q <= ST_WRITTEN;
      de_q     <= '0;
      cnt_q    <= '0;
    end else if (busy_q) begin
      case (uw.act)
        A_WSITE: begin
          if (pay_bad) begin
            status_q <= ST_BAD;
          end
        end
        A_WTHR: begin
          if (slot_bad) begin
            status_q <= ST_BAD;
          end else begin
            thr_q[slot_q] <= THR_W'(thr_sat);
          end
        end
        A_READ: begin
          status_q <= ST_READ;
        end
        A_CAPA: begin
          a_q <= mem_rdata_q;
          if (mem_rdata_q == OCC_VACANT) begin
            status_q <= ST_VACANT;
          end else if (dir_q > DIR_LAST) begin
            status_q <= ST_BAD;
          end
        end
        A_CAPB: begin
          b_q    <= mem_rdata_q;
          cnt_q  <= CNT_W'(1);
          reds_q <= '0;
          if (mem_rdata_q == a_q) begin
            status_q <= ST_SAME;
          end
        end
        A_ACC: begin
          reds_q <= reds_q + CNT_W'(mem_rdata_q == OCC_RED);
          cnt_q  <= cnt_q + CNT_W'(1);
        end
        A_ENERGY: begin
          de_q <= de_w;
        end
        A_DECIDE: begin
          status_q <= accept_move ? ST_ACCEPT : ST_REJECT;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register, loaded as the program finishes.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= status_q;
      out_de_q     <= de_q;
      out_occ_q    <= mem_rdata_q;
    end
  end

endmodule
